/* sv/chained_hash_map_unit_assert.svh */
// Assertion macros for the chained hash map unit
`ifndef CHAINED_HASH_MAP_UNIT_ASSERT_SVH
`define CHAINED_HASH_MAP_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define CHM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked every clock outside reset
`define CHM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* sv/chm_pkg.sv */
// Package for the chained hash map: sizes, codes and sequencer states
package chm_pkg;
   localparam int MAX_BUCKETS_DEF  = 256;
   localparam int POOL_ENTRIES_DEF = 1024;
   localparam int CFG_W            = 9;
   localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_SET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_PRESENT = 2'd0,
      ST_ABSENT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_HASH  = 12'b000000000100,
      S_HEAD  = 12'b000000001000,
      S_LOAD  = 12'b000000010000,
      S_RDN   = 12'b000000100000,
      S_CMP   = 12'b000001000000,
      S_ALLOC = 12'b000010000000,
      S_POP   = 12'b000100000000,
      S_WRITE = 12'b001000000000,
      S_FREE  = 12'b010000000000,
      S_RESP  = 12'b100000000000
   } state_type;
endpackage

/* sv/chained_hash_map_unit.sv */
// Top level of the chained hash map: sequencer, node pool and bucket heads
//   channel | direction | payload
//   req     | in        | cmd, key, value
//   rsp     | out       | status, value_out
//   csr     | in        | bucket_count
// After reset a clearing pass writes every bucket head to empty.
// One shared compare/subtract unit forms (key >> 2) mod bucket count one key bit a
// cycle in S_HASH, then the S_HEAD and S_LOAD states fetch the bucket head.
// The chain walk passes S_RDN and S_CMP per node; a miss adds S_ALLOC, a remove hit
// S_FREE, an insert S_WRITE (S_POP first for a freed node); CMD_NONE skips to S_RESP.
// The response holds until rsp_ready; req_ready returns the cycle after it is taken.
module chained_hash_map_unit
   import chm_pkg::*;
#(
   parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_cmd,
   input  logic [31:0]      req_key,
   input  logic [31:0]      req_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_value_out,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_bucket_count
);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW = BW + 1;
   localparam int PW = $clog2(POOL_ENTRIES);
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
   localparam logic [4:0] HASH_LAST = 5'd29;

   state_type state_ff, state_in;
   logic [CFG_W-1:0] cfg_ff;
   logic [1:0]  cmd_ff;
   logic [31:0] key_ff, val_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0] free_ff, free_in, fresh_ff, fresh_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] vout_ff, vout_in;

   // effective bucket count, 1..MAX_BUCKETS
   logic [NW-1:0] nb;
   always_comb begin
      if (cfg_ff == '0) begin
         nb = NW'(1);
      end else if (32'(cfg_ff) > 32'(MAX_BUCKETS)) begin
         nb = NW'(MAX_BUCKETS);
      end else begin
         nb = NW'(cfg_ff);
      end
   end

   // shared compare/subtract: shift in the next key bit, reduce by nb once
   logic [NW-1:0] rem_sh;
   logic [BW-1:0] rem_nx;
   always_comb begin
      rem_sh = {bkt_ff, key_ff[5'd31 - cnt_ff]};
      if (rem_sh >= nb) begin
         rem_nx = BW'(rem_sh - nb);
      end else begin
         rem_nx = rem_sh[BW-1:0];
      end
   end

   // heads RAM
   logic           hd_we;
   logic [BW-1:0]  hd_wa;
   logic [LW-1:0]  hd_wd, hd_rd;
   chm_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS > 1 ? MAX_BUCKETS : 2)) u_heads (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(bkt_ff), .rd_data(hd_rd)
   );

   logic          nd_we_k, nd_we_v, nd_we_l;
   logic [PW-1:0] nd_wa, nd_ra;
   logic [31:0]   nd_wk, nd_wv, nd_rk, nd_rv;
   logic [LW-1:0] nd_wl, nd_rl;
   chm_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_keys (
      .clock(clock), .wr_en(nd_we_k), .wr_addr(nd_wa), .wr_data(nd_wk),
      .rd_addr(nd_ra), .rd_data(nd_rk)
   );
   chm_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_vals (
      .clock(clock), .wr_en(nd_we_v), .wr_addr(nd_wa), .wr_data(nd_wv),
      .rd_addr(nd_ra), .rd_data(nd_rv)
   );
   chm_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_links (
      .clock(clock), .wr_en(nd_we_l), .wr_addr(nd_wa), .wr_data(nd_wl),
      .rd_addr(nd_ra), .rd_data(nd_rl)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_value_out = vout_ff;

   logic hit;
   assign hit = (nd_rk == key_ff);
   assign nd_ra = cur_ff[PW-1:0];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      bkt_in    = bkt_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      free_in   = free_ff;
      fresh_in  = fresh_ff;
      status_in = status_ff;
      vout_in   = vout_ff;
      steps_in  = steps_ff;
      hd_we = 1'b0; hd_wa = bkt_ff; hd_wd = NIL;
      nd_we_k = 1'b0; nd_we_v = 1'b0; nd_we_l = 1'b0;
      nd_wa = cur_ff[PW-1:0]; nd_wk = key_ff; nd_wv = val_ff; nd_wl = free_ff;
      unique case (state_ff)
         S_CLEAR: begin
            hd_we = 1'b1;
            bkt_in = bkt_ff + 1'b1;
            if (32'(bkt_ff) == 32'(MAX_BUCKETS - 1)) begin
               bkt_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               bkt_in = '0;
               cnt_in = '0;
               prev_in = NIL;
               steps_in = '0;
               status_in = ST_ABSENT;
               vout_in = '0;
               state_in = (req_cmd == CMD_NONE) ? S_RESP : S_HASH;
            end
         end
         S_HASH: begin
            bkt_in = rem_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == HASH_LAST) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            // head read in flight
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cur_in = hd_rd;
            state_in = S_RDN;
         end
         S_RDN: begin
            state_in = (cur_ff < NIL) ? S_CMP : S_ALLOC;
         end
         S_CMP: begin
            if (hit) begin
               status_in = ST_PRESENT;
               state_in = S_RESP;
               case (cmd_ff)
                  CMD_FIND: vout_in = nd_rv;
                  CMD_SET: nd_we_v = 1'b1;
                  CMD_REMOVE: begin
                     // unlink: predecessor or bucket head takes the successor
                     if (prev_ff < NIL) begin
                        nd_we_l = 1'b1;
                        nd_wa = prev_ff[PW-1:0];
                        nd_wl = nd_rl;
                     end else begin
                        hd_we = 1'b1;
                        hd_wd = nd_rl;
                     end
                     state_in = S_FREE;
                  end
                  default: ;
               endcase
            end else if (steps_ff >= NIL) begin
               state_in = S_ALLOC;
            end else begin
               prev_in = cur_ff;
               cur_in = nd_rl;
               steps_in = steps_ff + 1'b1;
               state_in = S_RDN;
            end
         end
         S_ALLOC: begin
            state_in = S_RESP;
            if (cmd_ff == CMD_SET) begin
               if (free_ff < NIL) begin
                  cur_in = free_ff;
                  state_in = S_POP;
               end else if (fresh_ff < NIL) begin
                  cur_in = fresh_ff;
                  fresh_in = fresh_ff + 1'b1;
                  state_in = S_WRITE;
               end else begin
                  status_in = ST_FULL;
               end
            end
         end
         S_POP: begin
            // link of the free head in flight
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // a node taken from the free list is its head: advance the list
            if (cur_ff == free_ff) begin
               free_in = nd_rl;
            end
            nd_we_k = 1'b1; nd_we_v = 1'b1; nd_we_l = 1'b1;
            nd_wl = hd_rd;
            hd_we = 1'b1;
            hd_wd = cur_ff;
            state_in = S_RESP;
         end
         S_FREE: begin
            nd_we_l = 1'b1;
            nd_wl = free_ff;
            free_in = cur_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cfg_ff   <= BUCKET_COUNT_RST;
         bkt_ff   <= '0;
         free_ff  <= NIL;
         fresh_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_bucket_count;
         end
         state_ff <= state_in;
         bkt_ff   <= bkt_in;
         free_ff  <= free_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
      steps_ff  <= steps_in;
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end
endmodule

/* sv/chm_ram.sv */
// Generic single-port-write, one-read RAM with registered read data
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* sv/chm_checker.sv */
// Port-level checker for the chained hash map, bound to the top level
`include "chained_hash_map_unit_assert.svh"
module chm_checker
   import chm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_value_out
);
   logic        req_take;
   logic        rsp_wait;
   logic        rsp_miss;
   logic [33:0] rsp_payload;
   assign req_take = req_valid && req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;
   assign rsp_miss = rsp_valid && (rsp_status != ST_PRESENT);
   assign rsp_payload = {rsp_status, rsp_value_out};

   `CHM_ASSERT_IMP(a_one_side, clock, reset, rsp_valid, !req_ready, "ready with response pending")
   `CHM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid, "response dropped")
   `CHM_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_payload), "response changed")
   `CHM_ASSERT_NXT(a_busy_after, clock, reset, req_take, !req_ready, "ready after request")
   `CHM_ASSERT_IMP(a_zero_val, clock, reset, rsp_miss, rsp_value_out == '0, "value on non-hit")
endmodule

bind chained_hash_map_unit chm_checker u_chm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_value_out(rsp_value_out)
);

/* tb/tb_chained_hash_map_unit.sv */
// Testbench for the chained hash map unit: queued requests, own map predictor, response check
module tb_chained_hash_map_unit;
   import chm_pkg::*;

   localparam int NIL = POOL_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] key;
      logic [31:0] value;
   } map_request_type;

   typedef struct {
      status_type  status;
      logic [31:0] value_out;
   } map_response_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_cmd;
   logic [31:0]      req_key;
   logic [31:0]      req_value;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [1:0]       rsp_status;
   logic [31:0]      rsp_value_out;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_bucket_count;

   chained_hash_map_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bucket_count (csr_bucket_count)
   );

   // map shadow state
   int          map_heads [MAX_BUCKETS_DEF] = '{default: NIL};
   logic [31:0] map_keys  [POOL_ENTRIES_DEF] = '{default: '0};
   logic [31:0] map_vals  [POOL_ENTRIES_DEF] = '{default: '0};
   int          map_links [POOL_ENTRIES_DEF] = '{default: 0};
   int          map_free_head = NIL;
   int          map_fresh_next = 0;
   logic [CFG_W-1:0] map_bucket_count = BUCKET_COUNT_RST;

   map_request_type  pending_requests[$];
   map_response_type expected_responses[$];
   logic [31:0]      key_pool[64];

   int  error_count;
   int  request_count;
   int  response_count;
   int  status_seen [4];
   int  csr_write_count;
   int  cycle_count;
   bit  steady_mode;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_mode || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic map_response_type apply_map_request(map_request_type rq);
      map_response_type rs;
      int n, b, prev, cur, steps, fresh;
      rs.status = ST_ABSENT;
      rs.value_out = '0;
      if (rq.cmd == CMD_NONE) return rs;
      n = int'(map_bucket_count);
      if (n == 0) n = 1;
      if (n > MAX_BUCKETS_DEF) n = MAX_BUCKETS_DEF;
      b = int'((rq.key >> 2) % 32'(n));
      prev = NIL;
      cur = map_heads[b];
      steps = 0;
      while (cur < NIL && steps <= NIL) begin
         if (map_keys[cur] == rq.key) break;
         prev = cur;
         cur = map_links[cur];
         steps++;
      end
      if (steps > NIL) cur = NIL;
      case (rq.cmd)
         CMD_FIND: begin
            if (cur < NIL) begin
               rs.status = ST_PRESENT;
               rs.value_out = map_vals[cur];
            end
         end
         CMD_SET: begin
            if (cur < NIL) begin
               map_vals[cur] = rq.value;
               rs.status = ST_PRESENT;
            end else begin
               fresh = NIL;
               if (map_free_head < NIL) begin
                  fresh = map_free_head;
                  map_free_head = map_links[fresh];
               end else if (map_fresh_next < NIL) begin
                  fresh = map_fresh_next;
                  map_fresh_next++;
               end
               if (fresh < NIL) begin
                  map_keys[fresh] = rq.key;
                  map_vals[fresh] = rq.value;
                  map_links[fresh] = map_heads[b];
                  map_heads[b] = fresh;
               end else begin
                  rs.status = ST_FULL;
               end
            end
         end
         default: begin
            if (cur < NIL) begin
               if (prev < NIL) map_links[prev] = map_links[cur];
               else map_heads[b] = map_links[cur];
               map_links[cur] = map_free_head;
               map_free_head = cur;
               rs.status = ST_PRESENT;
            end
         end
      endcase
      return rs;
   endfunction

   // request driver
   int drive_gap;
   always @(posedge clock) begin
      map_request_type  rq;
      map_response_type rs;
      logic             next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd   <= '0;
         req_key   <= '0;
         req_value <= '0;
         drive_gap = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            rq.cmd   = cmd_type'(req_cmd);
            rq.key   = req_key;
            rq.value = req_value;
            rs = apply_map_request(rq);
            expected_responses.push_back(rs);
            request_count++;
            next_valid = 1'b0;
            drive_gap = idle_gap();
         end
         if (!next_valid) begin
            if (drive_gap > 0) begin
               drive_gap--;
            end else if (pending_requests.size() > 0) begin
               rq = pending_requests.pop_front();
               req_cmd   <= rq.cmd;
               req_key   <= rq.key;
               req_value <= rq.value;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // response monitor and backpressure
   int stall_left;
   always @(posedge clock) begin
      map_response_type rs;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            response_count++;
            status_seen[rsp_status]++;
            if (expected_responses.size() == 0) begin
               $display("%0t: response with nothing expected: status %0d value %h",
                        $time, rsp_status, rsp_value_out);
               error_count++;
            end else begin
               rs = expected_responses.pop_front();
               if (rsp_status !== rs.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, rs.status, rsp_status);
                  error_count++;
               end
               if (rsp_value_out !== rs.value_out) begin
                  $display("%0t: value_out expected %h actual %h",
                           $time, rs.value_out, rsp_value_out);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = idle_gap();
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   // cycle limit and idle-stretch toggle
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 97 == 0) steady_mode <= ($urandom_range(0, 3) == 0);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_responses.size());
         $display("chained_hash_map_unit verification failed");
         $finish;
      end
   end

   task automatic queue_request(cmd_type cmd, logic [31:0] key, logic [31:0] value);
      map_request_type rq;
      rq.cmd = cmd;
      rq.key = key;
      rq.value = value;
      pending_requests.push_back(rq);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bucket_count(logic [CFG_W-1:0] count);
      csr_valid <= 1'b1;
      csr_bucket_count <= count;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      map_bucket_count = count;
      csr_write_count++;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(int count);
      int r;
      cmd_type cmd;
      logic [31:0] key;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) cmd = CMD_FIND;
         else if (r < 72) cmd = CMD_SET;
         else if (r < 95) cmd = CMD_REMOVE;
         else cmd = CMD_NONE;
         key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 63)] : $urandom;
         queue_request(cmd, key, $urandom);
      end
   endtask

   initial begin
      csr_write_count = 0;
      for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_bucket_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // extremes, every command, collisions, unlink from middle, free-list reuse
      queue_request(CMD_SET,    32'h0,        32'h0);
      queue_request(CMD_SET,    32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_request(CMD_FIND,   32'h0,        32'h12345678);
      queue_request(CMD_FIND,   32'hFFFFFFFF, 32'h0);
      queue_request(CMD_FIND,   32'h00000001, 32'h0);
      queue_request(CMD_SET,    32'h0,        32'hA5A5A5A5);
      queue_request(CMD_FIND,   32'h0,        32'h0);
      queue_request(CMD_NONE,   32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_request(CMD_SET,    32'h00000400, 32'h11111111);
      queue_request(CMD_SET,    32'h00000800, 32'h22222222);
      queue_request(CMD_SET,    32'h00000C00, 32'h33333333);
      queue_request(CMD_REMOVE, 32'h00000800, 32'h0);
      queue_request(CMD_FIND,   32'h00000400, 32'h0);
      queue_request(CMD_FIND,   32'h00000C00, 32'h0);
      queue_request(CMD_FIND,   32'h00000800, 32'h0);
      queue_request(CMD_REMOVE, 32'h00000800, 32'h0);
      queue_request(CMD_REMOVE, 32'h00000C00, 32'h0);
      queue_request(CMD_REMOVE, 32'h0,        32'h0);
      queue_request(CMD_SET,    32'h00000003, 32'h5A5A5A5A);
      queue_request(CMD_FIND,   32'h00000003, 32'h0);
      queue_request(CMD_FIND,   32'h0,        32'h0);
      queue_request(CMD_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF);
      wait_drained();

      // one, zero, oversized, three and 256 buckets: old entries can strand in other buckets
      write_bucket_count(9'd1);
      queue_random(100);
      wait_drained();
      write_bucket_count(9'd0);
      queue_random(50);
      wait_drained();
      write_bucket_count(9'd300);
      queue_random(60);
      wait_drained();
      write_bucket_count(9'd511);
      queue_random(40);
      wait_drained();
      write_bucket_count(9'd3);
      queue_random(70);
      wait_drained();
      write_bucket_count(9'd256);
      queue_random(70);
      wait_drained();

      // free a few pooled keys, then reuse the freed nodes
      for (int i = 0; i < 16; i++) queue_request(CMD_REMOVE, key_pool[i], 32'h0);
      queue_random(40);
      wait_drained();

      repeat (200) @(posedge clock);
      $display("%0d requests, %0d responses (present %0d, absent %0d, full %0d)",
               request_count, response_count, status_seen[ST_PRESENT],
               status_seen[ST_ABSENT], status_seen[ST_FULL]);
      $display("%0d bucket count writes, including zero and oversized counts",
               csr_write_count);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("chained_hash_map_unit verification clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", error_count,
                  expected_responses.size());
         $display("chained_hash_map_unit verification failed");
      end
      $finish;
   end

endmodule
